@@ rtl/hrl_pkg.sv @@
// hrl_pkg: shared types, constants and the digit decode for the hex record loader.
// No dependencies; used by hrl_parser, hrl_out_reg and hex_record_loader.
package hrl_pkg;

	localparam logic [7:0] CHAR_ZERO    = 8'h30;  // '0'
	localparam logic [7:0] CHAR_NINE    = 8'h39;  // '9'
	localparam logic [7:0] CHAR_SEVEN   = 8'h37;  // '7'
	localparam logic [7:0] CHAR_NEWLINE = 8'h0A;

	typedef enum logic [5:0] {
		PH_START = 6'b000001,
		PH_COUNT = 6'b000010,
		PH_ADDR  = 6'b000100,
		PH_TYPE  = 6'b001000,
		PH_DATA  = 6'b010000,
		PH_SKIP  = 6'b100000
	} phase_t;

	typedef struct packed {
		logic [15:0] write_address;
		logic [7:0]  write_data;
		logic        is_end;
		logic [15:0] total_loaded;
	} result_t;

	// Uppercase hex digit decode; any other character gives the low 4 bits of itself minus 0x30, or minus 0x37 above '9'.
	function automatic logic [3:0] hex_value(input logic [7:0] c);
		logic [7:0] diff;
		begin
			diff = (c > CHAR_NINE) ? (c - CHAR_SEVEN) : (c - CHAR_ZERO);
			hex_value = diff[3:0];
		end
	endfunction

endpackage

@@ rtl/hrl_parser.sv @@
// hrl_parser: input register and the record parsing state machine.
// Depends on hrl_pkg (phase_t, result_t, hex_value).
module hrl_parser (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic [7:0]           character,
	input  logic                 adv,
	output logic                 res_valid,
	output hrl_pkg::result_t     res
);
	import hrl_pkg::*;

	logic        vld_s1;
	logic [7:0]  char_s1;
	logic        consume;

	phase_t      phase_q, phase_d;
	logic [1:0]  digit_q, digit_d;
	logic [7:0]  count_q, count_d;
	logic [15:0] addr_q, addr_d;
	logic [3:0]  nib_q, nib_d;
	logic [7:0]  offset_q, offset_d;
	logic [15:0] total_q, total_d;
	logic        done_q, done_d;

	logic [3:0]  d;
	logic [7:0]  byte_val;
	logic [8:0]  next_off;

	assign consume  = vld_s1 && adv;
	assign in_stall = vld_s1 && !adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (!in_stall) begin
			vld_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall && in_valid) begin
			char_s1 <= character;
		end
	end

	assign d        = hex_value(char_s1);
	assign byte_val = {nib_q, d};
	assign next_off = {1'b0, offset_q} + 9'd1;

	always_comb begin
		phase_d   = phase_q;
		digit_d   = digit_q;
		count_d   = count_q;
		addr_d    = addr_q;
		nib_d     = nib_q;
		offset_d  = offset_q;
		total_d   = total_q;
		done_d    = done_q;
		res_valid = 1'b0;
		res       = '0;
		// an empty input register must not produce a beat from stale text
		if (vld_s1 && !done_q) begin
			unique case (phase_q)
				PH_START: begin
					phase_d = PH_COUNT;
					digit_d = 2'd0;
				end
				PH_COUNT: begin
					if (digit_q == 2'd0) begin
						nib_d   = d;
						digit_d = 2'd1;
					end else begin
						count_d = byte_val;
						digit_d = 2'd0;
						if (byte_val == 8'd0) begin
							done_d             = 1'b1;
							res_valid          = 1'b1;
							res.is_end         = 1'b1;
							res.total_loaded   = total_q;
						end else begin
							phase_d = PH_ADDR;
						end
					end
				end
				PH_ADDR: begin
					addr_d = {addr_q[11:0], d};
					if (digit_q == 2'd3) begin
						digit_d = 2'd0;
						phase_d = PH_TYPE;
					end else begin
						digit_d = digit_q + 2'd1;
					end
				end
				PH_TYPE: begin
					if (digit_q == 2'd0) begin
						digit_d = 2'd1;
					end else begin
						digit_d  = 2'd0;
						offset_d = 8'd0;
						phase_d  = PH_DATA;
					end
				end
				PH_DATA: begin
					if (digit_q == 2'd0) begin
						nib_d   = d;
						digit_d = 2'd1;
					end else begin
						digit_d  = 2'd0;
						total_d  = total_q + 16'd1;
						offset_d = next_off[7:0];
						if (next_off >= {1'b0, count_q}) begin
							phase_d = PH_SKIP;
						end
						res_valid         = 1'b1;
						res.write_address = addr_q + {8'd0, offset_q};
						res.write_data    = byte_val;
						res.is_end        = 1'b0;
						res.total_loaded  = total_q + 16'd1;
					end
				end
				PH_SKIP: begin
					if (char_s1 == CHAR_NEWLINE) begin
						phase_d = PH_START;
						digit_d = 2'd0;
					end
				end
				default: begin
					phase_d = PH_COUNT;
					digit_d = 2'd0;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_START;
			digit_q  <= 2'd0;
			count_q  <= 8'd0;
			addr_q   <= 16'd0;
			nib_q    <= 4'd0;
			offset_q <= 8'd0;
			total_q  <= 16'd0;
			done_q   <= 1'b0;
		end else if (consume) begin
			phase_q  <= phase_d;
			digit_q  <= digit_d;
			count_q  <= count_d;
			addr_q   <= addr_d;
			nib_q    <= nib_d;
			offset_q <= offset_d;
			total_q  <= total_d;
			done_q   <= done_d;
		end
	end

endmodule

@@ rtl/hrl_out_reg.sv @@
// hrl_out_reg: result register holding one beat for the output channel.
// Depends on hrl_pkg (result_t).
module hrl_out_reg (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             res_valid,
	input  hrl_pkg::result_t res,
	output logic             adv,
	output logic             out_valid,
	input  logic             out_stall,
	output hrl_pkg::result_t out_res
);
	import hrl_pkg::*;

	logic    vld_q;
	result_t res_q;

	// Space when empty or when the held beat leaves this cycle.
	assign adv       = !vld_q || !out_stall;
	assign out_valid = vld_q;
	assign out_res   = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (adv) begin
			vld_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && res_valid) begin
			res_q <= res;
		end
	end

endmodule

@@ rtl/hex_record_loader.sv @@
// Hex record loader: takes Intel HEX text one character per beat and emits one
// beat per decoded data byte (address, byte, running total) and one end beat when
// a zero-count record is seen; after that all characters are dropped. Each
// character is registered, the parser state updates in a single pass, and any
// result lands in the output register, so one character per cycle is sustained
// while the output side takes beats. Checksums are not checked, lowercase is
// not decoded.
// Depends on hrl_pkg, hrl_parser and hrl_out_reg.
module hex_record_loader (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  character,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [15:0] write_address,
	output logic [7:0]  write_data,
	output logic        is_end,
	output logic [15:0] total_loaded
);
	import hrl_pkg::*;

	logic    adv;
	logic    res_valid;
	result_t res;
	result_t out_res;

	hrl_parser u_parser (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.character (character),
		.adv       (adv),
		.res_valid (res_valid),
		.res       (res)
	);

	hrl_out_reg u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.res_valid (res_valid),
		.res       (res),
		.adv       (adv),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_res   (out_res)
	);

	assign write_address = out_res.write_address;
	assign write_data    = out_res.write_data;
	assign is_end        = out_res.is_end;
	assign total_loaded  = out_res.total_loaded;

endmodule
